// ----- src/swfrm_pkg.sv -----
// shared constants, field widths and types for the sliding window frame rate meter
// no dependencies; imported by every module of the block
package swfrm_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int MIN_KEEP         = 2;
    localparam int MIN_CAP          = 3;

    localparam int SIZE_W    = 32;
    localparam int TS_W      = 48;
    localparam int SPAN_W    = 36;
    localparam int MAXE_W    = 7;
    localparam int TOTAL_W   = 32;
    localparam int ENTRIES_W = 7;
    localparam int FPS_W     = 24;
    localparam int MBPS_W    = 32;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 36;

    // dividend and divisor of the shared divider
    localparam int NUM_W = 64;
    localparam int DEN_W = TS_W;

    // 1e11 = 5^11 * 2^11, 800000 = 5^5 * 2^8
    localparam int STEP_W          = 4;
    localparam int FPS_MUL5_STEPS  = 11;
    localparam int FPS_SHIFT       = 11;
    localparam int MBPS_MUL5_STEPS = 5;
    localparam int MBPS_SHIFT      = 8;

    localparam logic [SPAN_W-1:0] SPAN_RESET        = 36'd5000000000;
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 7'd50;
    localparam logic [FPS_W-1:0]  FPS_MAX           = '1;
    localparam logic [MBPS_W-1:0] MBPS_MAX          = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX        = '1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SPAN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd1;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic done;
        logic round_up;
    } div_stat_t;

endpackage

// ----- src/swfrm_div.sv -----
// restoring divider, one quotient bit per cycle, with round-half-up flag
// depends on swfrm_pkg
module swfrm_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [swfrm_pkg::NUM_W-1:0]  num,
    input  logic [swfrm_pkg::DEN_W-1:0]  den,
    output logic [swfrm_pkg::NUM_W-1:0]  quo,
    output swfrm_pkg::div_stat_t         stat
);
    import swfrm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_next = diff[DEN_W-1:0];
            end else begin
                rem_next = shifted[DEN_W-1:0];
            end
            quo_next = {quo_reg[NUM_W-2:0], ~diff[DEN_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo           = quo_reg;
    assign stat.done     = done_reg;
    assign stat.round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};

endmodule

// ----- src/sliding_window_frame_rate_meter_top.sv -----
// sliding window frame rate meter: window rings, eviction sequencer, rate scaling
// depends on swfrm_pkg and swfrm_div
// sequence: a clear item goes straight to the result; a frame item drops entries over the
// cap, appends, ages out, then, when rates are valid, scales and divides for fps and mbps
// throughput: one item at a time, the next is taken the cycle after the result loads
// reset: control, counters and config registers return to defaults; datapath registers and rings are not cleared
module sliding_window_frame_rate_meter_top #(
    parameter int WINDOW_DEPTH = swfrm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // frame_size, timestamp_ns
    input  logic [swfrm_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // total_frames, window_entries, fps_centi, mbps_centi, zero pad
    output logic [swfrm_pkg::M_TDATA_W-1:0]   m_tdata,
    // rate_valid
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swfrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swfrm_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import swfrm_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SIZE_W + ADDR_W;
    localparam int CMP_W  = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b00000000001,
        S_EVICT_CHK  = 11'b00000000010,
        S_EVICT_DROP = 11'b00000000100,
        S_APPEND     = 11'b00000001000,
        S_AGE_WAIT   = 11'b00000010000,
        S_AGE_CHK    = 11'b00000100000,
        S_FMUL       = 11'b00001000000,
        S_FDIV       = 11'b00010000000,
        S_MMUL       = 11'b00100000000,
        S_MDIV       = 11'b01000000000,
        S_DONE       = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [SPAN_W-1:0]   window_span_reg, window_span_next;
    logic [MAXE_W-1:0]   max_entries_reg, max_entries_next;
    logic [ADDR_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SIZE_W-1:0]   size_in_reg, size_in_next;
    logic [TS_W-1:0]     ts_in_reg, ts_in_next;
    logic [TS_W-1:0]     span_reg, span_next;
    logic [SUM_W-1:0]    bytes_reg, bytes_next;
    logic [NUM_W-1:0]    mul_reg, mul_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                valid_res_reg, valid_res_next;
    logic [FPS_W-1:0]    fps_reg, fps_next;
    logic [MBPS_W-1:0]   mbps_reg, mbps_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic [TS_W-1:0]     time_mem [WINDOW_DEPTH];
    logic [SIZE_W-1:0]   size_mem [WINDOW_DEPTH];
    logic [TS_W-1:0]     rd_time_reg;
    logic [SIZE_W-1:0]   rd_size_reg;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_slot;
    logic [CNT_W:0]      slot_sum;

    logic [CMP_W-1:0]    max_ext, depth_ext, cap_ext, count_ext;
    logic                need_evict;
    logic [ADDR_W-1:0]   oldest_inc;
    logic [TS_W-1:0]     age_span;
    logic                span_pos;
    logic                age_drop;

    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [NUM_W-1:0]    div_quo;
    div_stat_t           div_stat;
    logic [NUM_W:0]      q_round;

    logic                in_accept;
    logic                out_load;

    swfrm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (span_reg),
        .quo     (div_quo),
        .stat    (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_slot] <= ts_in_reg;
            size_mem[wr_slot] <= size_in_reg;
        end
        rd_time_reg <= time_mem[oldest_reg];
        rd_size_reg <= size_mem[oldest_reg];
    end

    always_comb begin
        in_accept = s_tvalid && (state_reg == S_IDLE);
        max_ext   = CMP_W'(max_entries_reg);
        depth_ext = CMP_W'(WINDOW_DEPTH);
        if (max_ext < CMP_W'(MIN_CAP)) begin
            cap_ext = CMP_W'(MIN_CAP);
        end else if (max_ext > depth_ext) begin
            cap_ext = depth_ext;
        end else begin
            cap_ext = max_ext;
        end
        count_ext  = CMP_W'(count_reg);
        need_evict = (count_reg != '0) && (count_ext >= cap_ext);
        oldest_inc = (oldest_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
        slot_sum   = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(count_reg);
        if (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
            slot_sum = slot_sum - (CNT_W + 1)'(WINDOW_DEPTH);
        end
        wr_slot  = slot_sum[ADDR_W-1:0];
        age_span = ts_in_reg - rd_time_reg;
        span_pos = ts_in_reg > rd_time_reg;
        age_drop = (count_reg > CNT_W'(MIN_KEEP)) && span_pos
                   && (age_span > TS_W'(window_span_reg));
        div_num  = (state_reg == S_MMUL) ? (mul_reg << MBPS_SHIFT) : (mul_reg << FPS_SHIFT);
        q_round  = (NUM_W + 1)'(div_quo) + (NUM_W + 1)'(div_stat.round_up);
        out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        state_next       = state_reg;
        window_span_next = window_span_reg;
        max_entries_next = max_entries_reg;
        oldest_next      = oldest_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        total_next       = total_reg;
        size_in_next     = size_in_reg;
        ts_in_next       = ts_in_reg;
        span_next        = span_reg;
        bytes_next       = bytes_reg;
        mul_next         = mul_reg;
        step_next        = step_reg;
        valid_res_next   = valid_res_reg;
        fps_next         = fps_reg;
        mbps_next        = mbps_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        wr_en            = 1'b0;
        div_start        = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_SPAN: window_span_next = cfg_data[SPAN_W-1:0];
                REG_MAX_ENTRIES: max_entries_next = cfg_data[MAXE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    size_in_next = s_tdata[SIZE_W-1:0];
                    ts_in_next   = s_tdata[SIZE_W +: TS_W];
                    if (s_tuser == REQ_CLEAR) begin
                        oldest_next    = '0;
                        count_next     = '0;
                        sum_next       = '0;
                        total_next     = '0;
                        valid_res_next = 1'b0;
                        fps_next       = '0;
                        mbps_next      = '0;
                        state_next     = S_DONE;
                    end else begin
                        state_next = S_EVICT_CHK;
                    end
                end
            end
            S_EVICT_CHK: begin
                state_next = need_evict ? S_EVICT_DROP : S_APPEND;
            end
            S_EVICT_DROP: begin
                sum_next    = sum_reg - SUM_W'(rd_size_reg);
                oldest_next = oldest_inc;
                count_next  = count_reg - 1'b1;
                state_next  = S_EVICT_CHK;
            end
            S_APPEND: begin
                wr_en      = 1'b1;
                sum_next   = sum_reg + SUM_W'(size_in_reg);
                count_next = count_reg + 1'b1;
                if (total_reg != TOTAL_MAX) begin
                    total_next = total_reg + 1'b1;
                end
                state_next = S_AGE_WAIT;
            end
            S_AGE_WAIT: begin
                state_next = S_AGE_CHK;
            end
            S_AGE_CHK: begin
                if (age_drop) begin
                    sum_next    = sum_reg - SUM_W'(rd_size_reg);
                    oldest_next = oldest_inc;
                    count_next  = count_reg - 1'b1;
                    state_next  = S_AGE_WAIT;
                end else if ((count_reg >= CNT_W'(MIN_KEEP)) && span_pos) begin
                    valid_res_next = 1'b1;
                    span_next      = age_span;
                    bytes_next     = sum_reg - SUM_W'(rd_size_reg);
                    mul_next       = NUM_W'(count_reg - 1'b1);
                    step_next      = STEP_W'(FPS_MUL5_STEPS);
                    state_next     = S_FMUL;
                end else begin
                    valid_res_next = 1'b0;
                    fps_next       = '0;
                    mbps_next      = '0;
                    state_next     = S_DONE;
                end
            end
            S_FMUL: begin
                if (step_reg != '0) begin
                    mul_next  = mul_reg + (mul_reg << 2);
                    step_next = step_reg - 1'b1;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_stat.done) begin
                    fps_next   = (q_round > (NUM_W + 1)'(FPS_MAX)) ? FPS_MAX
                                                                   : q_round[FPS_W-1:0];
                    mul_next   = NUM_W'(bytes_reg);
                    step_next  = STEP_W'(MBPS_MUL5_STEPS);
                    state_next = S_MMUL;
                end
            end
            S_MMUL: begin
                if (step_reg != '0) begin
                    mul_next  = mul_reg + (mul_reg << 2);
                    step_next = step_reg - 1'b1;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_MDIV;
                end
            end
            S_MDIV: begin
                if (div_stat.done) begin
                    mbps_next  = (q_round > (NUM_W + 1)'(MBPS_MAX)) ? MBPS_MAX
                                                                    : q_round[MBPS_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, mbps_reg, fps_reg, ENTRIES_W'(count_reg), total_reg};
                    m_tuser_next  = valid_res_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            window_span_reg <= SPAN_RESET;
            max_entries_reg <= MAX_ENTRIES_RESET;
            oldest_reg      <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            total_reg       <= '0;
            step_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            window_span_reg <= window_span_next;
            max_entries_reg <= max_entries_next;
            oldest_reg      <= oldest_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            total_reg       <= total_next;
            step_reg        <= step_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        size_in_reg   <= size_in_next;
        ts_in_reg     <= ts_in_next;
        span_reg      <= span_next;
        bytes_reg     <= bytes_next;
        mul_reg       <= mul_next;
        valid_res_reg <= valid_res_next;
        fps_reg       <= fps_next;
        mbps_reg      <= mbps_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ----- src/swfrm_checker.sv -----
// port-level checks for the sliding window frame rate meter, bound to the top level
// depends on swfrm_pkg and sliding_window_frame_rate_meter_top
module swfrm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [swfrm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             m_tuser
);
    import swfrm_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");

    // invalid rates read zero
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[62:39] == '0) && (m_tdata[94:63] == '0))
        else $error("invalid rate not zero");

    // valid rate needs two entries
    a_valid_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[38:32] != 7'd0) && (m_tdata[38:32] != 7'd1))
        else $error("valid rate with fewer than two entries");

    // window never holds more than frames counted
    a_entries_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {25'd0, m_tdata[38:32]} <= m_tdata[31:0])
        else $error("window entries exceed frame total");

endmodule

bind sliding_window_frame_rate_meter_top swfrm_checker u_swfrm_checker (.*);

// ----- tb/sv/tb_sliding_window_frame_rate_meter_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for sliding_window_frame_rate_meter_top
// depends on swfrm_pkg and the meter rtl; predicts results from a local window copy, some fixed in the plan
module tb_sliding_window_frame_rate_meter_top;
    import swfrm_pkg::*;

    localparam int DEPTH       = 64;
    localparam int QUIET_LIMIT = 20000;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 100;
    localparam int PLAN_MAX    = 64;
    localparam int DUE_DEPTH   = 16;

    typedef struct packed {
        logic [TOTAL_W-1:0]   total;
        logic [ENTRIES_W-1:0] entries;
        logic                 valid;
        logic [FPS_W-1:0]     fps;
        logic [MBPS_W-1:0]    mbps;
    } meter_out_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] cdata;
        logic                 req;
        logic [SIZE_W-1:0]    size;
        logic [TS_W-1:0]      ts;
        logic                 typed;
        meter_out_t           want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    sliding_window_frame_rate_meter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the window
    logic [TS_W-1:0]      win_ts [DEPTH];
    logic [SIZE_W-1:0]    win_size [DEPTH];
    logic [5:0]           win_head;
    logic [6:0]           win_fill;
    logic [37:0]          win_bytes;
    logic [TOTAL_W-1:0]   win_frames;
    logic [SPAN_W-1:0]    span_limit;
    logic [MAXE_W-1:0]    entry_cap;

    // expected results in order, written at accept and read at the output
    meter_out_t due_ring [DUE_DEPTH];
    int         due_wr         = 0;
    int         due_rd         = 0;
    plan_row_t  plan [PLAN_MAX];
    int         plan_len       = 0;
    int         mismatches     = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         quiet_cycles   = 0;
    meter_out_t got_out;
    meter_out_t want_out;

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [63:0] pick_below(logic [63:0] n);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r % n;
    endfunction

    function automatic meter_out_t mk_out(logic [31:0] t, logic [6:0] e, logic v,
                                          logic [23:0] f, logic [31:0] m);
        meter_out_t o;
        o.total   = t;
        o.entries = e;
        o.valid   = v;
        o.fps     = f;
        o.mbps    = m;
        return o;
    endfunction

    function automatic logic [TS_W-1:0] window_span();
        logic [TS_W-1:0] first;
        logic [TS_W-1:0] last;
        if (win_fill < 2) return '0;
        first = win_ts[win_head];
        last  = win_ts[6'(win_head + win_fill[5:0] - 6'd1)];
        if (last <= first) return '0;
        return last - first;
    endfunction

    function automatic logic [63:0] div_round(logic [63:0] num, logic [63:0] den,
                                              logic [63:0] maxv);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (r >= den - r) q = q + 1;
        return (q > maxv) ? maxv : q;
    endfunction

    task automatic drop_oldest();
        win_bytes = win_bytes - 38'(win_size[win_head]);
        win_head  = win_head + 6'd1;
        win_fill  = win_fill - 7'd1;
    endtask

    task automatic meter_step(input logic req, input logic [SIZE_W-1:0] size,
                              input logic [TS_W-1:0] ts, output meter_out_t res);
        logic [6:0]      cap;
        logic [5:0]      slot;
        logic [TS_W-1:0] span;
        logic [37:0]     bytes;
        if (req == REQ_CLEAR) begin
            win_head   = '0;
            win_fill   = '0;
            win_bytes  = '0;
            win_frames = '0;
        end else begin
            cap = entry_cap;
            if (cap < 7'd3) cap = 7'd3;
            if (cap > 7'(DEPTH)) cap = 7'(DEPTH);
            while (win_fill > 0 && win_fill >= cap) drop_oldest();
            slot           = win_head + win_fill[5:0];
            win_size[slot] = size;
            win_ts[slot]   = ts;
            win_bytes      = win_bytes + 38'(size);
            win_fill       = win_fill + 7'd1;
            if (win_frames != TOTAL_MAX) win_frames = win_frames + 1;
            while (win_fill > 7'(MIN_KEEP) && window_span() > 48'(span_limit)) drop_oldest();
        end
        span        = window_span();
        res.total   = win_frames;
        res.entries = win_fill;
        res.valid   = (span != 0);
        res.fps     = '0;
        res.mbps    = '0;
        if (res.valid) begin
            bytes    = win_bytes - 38'(win_size[win_head]);
            res.fps  = FPS_W'(div_round(64'(win_fill - 7'd1) * 64'd100000000000,
                                        64'(span), 64'(FPS_MAX)));
            res.mbps = MBPS_W'(div_round(64'(bytes) * 64'd800000, 64'(span),
                                         64'(MBPS_MAX)));
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_wr == due_rd) begin
                report_mismatch("unexpected item", 64'(m_tdata), 64'd0);
            end else begin
                want_out         = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                got_out.total    = m_tdata[31:0];
                got_out.entries  = m_tdata[38:32];
                got_out.fps      = m_tdata[62:39];
                got_out.mbps     = m_tdata[94:63];
                got_out.valid    = m_tuser;
                if (got_out.total !== want_out.total)
                    report_mismatch("total_frames", 64'(got_out.total), 64'(want_out.total));
                if (got_out.entries !== want_out.entries)
                    report_mismatch("window_entries", 64'(got_out.entries),
                                    64'(want_out.entries));
                if (got_out.valid !== want_out.valid)
                    report_mismatch("rate_valid", 64'(got_out.valid), 64'(want_out.valid));
                if (got_out.fps !== want_out.fps)
                    report_mismatch("fps_centi", 64'(got_out.fps), 64'(want_out.fps));
                if (got_out.mbps !== want_out.mbps)
                    report_mismatch("mbps_centi", 64'(got_out.mbps), 64'(want_out.mbps));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** sliding_window_frame_rate_meter_top: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with the item accepted
    task automatic push_item(input logic req, input logic [SIZE_W-1:0] size,
                             input logic [TS_W-1:0] ts, input logic typed,
                             input meter_out_t want);
        meter_out_t pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {ts, size};
        do @(posedge aclk); while (!s_tready);
        meter_step(req, size, ts, pred);
        due_ring[due_wr % DUE_DEPTH] = typed ? want : pred;
        due_wr++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        s_tvalid = 1'b0;
        while (due_wr != due_rd) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_WINDOW_SPAN) span_limit = data;
        else entry_cap = data[MAXE_W-1:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        plan_row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.cdata = data;
        r.req   = REQ_FRAME;
        r.size  = '0;
        r.ts    = '0;
        r.typed = 1'b0;
        r.want  = '0;
        plan[plan_len] = r;
        plan_len++;
    endtask

    task automatic plan_item(input logic req, input logic [SIZE_W-1:0] size,
                             input logic [TS_W-1:0] ts);
        plan_row_t r;
        r.kind  = ROW_ITEM;
        r.idx   = '0;
        r.cdata = '0;
        r.req   = req;
        r.size  = size;
        r.ts    = ts;
        r.typed = 1'b0;
        r.want  = '0;
        plan[plan_len] = r;
        plan_len++;
    endtask

    task automatic plan_check(input logic req, input logic [SIZE_W-1:0] size,
                              input logic [TS_W-1:0] ts, input meter_out_t want);
        plan_item(req, size, ts);
        plan[plan_len-1].typed = 1'b1;
        plan[plan_len-1].want  = want;
    endtask

    initial begin
        logic [TS_W-1:0]      cur_ts;
        logic [SIZE_W-1:0]    size;
        logic                 req;
        logic [CFG_DAT_W-1:0] span_pick;
        logic [MAXE_W-1:0]    cap_pick;
        int                   r;

        win_head   = '0;
        win_fill   = '0;
        win_bytes  = '0;
        win_frames = '0;
        span_limit = SPAN_RESET;
        entry_cap  = MAX_ENTRIES_RESET;

        // reset defaults: extremes, equal stamps, age drop, stamp going back
        plan_check(REQ_CLEAR, '1, '1, mk_out(32'd0, 7'd0, 1'b0, 24'd0, 32'd0));
        plan_check(REQ_FRAME, 32'd0, 48'd0, mk_out(32'd1, 7'd1, 1'b0, 24'd0, 32'd0));
        plan_check(REQ_FRAME, '1, 48'd0, mk_out(32'd2, 7'd2, 1'b0, 24'd0, 32'd0));
        plan_check(REQ_FRAME, '1, 48'd1, mk_out(32'd3, 7'd3, 1'b1, FPS_MAX, MBPS_MAX));
        plan_item(REQ_FRAME, 32'd1500, 48'd1000000000);
        plan_item(REQ_FRAME, 32'd64, 48'd6000000000);
        plan_item(REQ_FRAME, 32'd9000, 48'd10);
        plan_item(REQ_FRAME, 32'd1, '1);
        plan_check(REQ_CLEAR, 32'h5555aaaa, 48'h123456789abc,
                   mk_out(32'd0, 7'd0, 1'b0, 24'd0, 32'd0));
        // widest span, cap above depth, then cap lowered below the fill
        plan_cfg(REG_WINDOW_SPAN, '1);
        plan_cfg(REG_MAX_ENTRIES, 36'd127);
        for (int i = 0; i < 6; i++) plan_item(REQ_FRAME, 32'd1000 + 32'(i * 77), 48'(i * 1000));
        plan_cfg(REG_MAX_ENTRIES, 36'd4);
        plan_item(REQ_FRAME, 32'd4000, 48'd7000);
        // zero span drops everything past the minimum
        plan_cfg(REG_WINDOW_SPAN, 36'd0);
        plan_item(REQ_FRAME, 32'd300, 48'd7000);
        plan_item(REQ_FRAME, 32'd301, 48'd7001);
        // cap below the minimum
        plan_cfg(REG_WINDOW_SPAN, SPAN_RESET);
        plan_cfg(REG_MAX_ENTRIES, 36'd0);
        for (int i = 0; i < 4; i++) plan_item(REQ_FRAME, 32'd50 + 32'(i), 48'd8000 + 48'(i * 3));

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < plan_len; i++) begin
            if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].cdata);
            else push_item(plan[i].req, plan[i].size, plan[i].ts, plan[i].typed, plan[i].want);
        end

        cur_ts = 48'd1000;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    span_pick = SPAN_RESET;
                    cap_pick  = 7'd64;
                end
                1: begin
                    span_pick = 36'd20000;
                    cap_pick  = 7'd3;
                end
                2: begin
                    span_pick = CFG_DAT_W'(pick_below(64'hFFFFFFFFF) + 1);
                    cap_pick  = MAXE_W'(3 + pick_below(62));
                end
                default: begin
                    span_pick = '1;
                    cap_pick  = 7'd2;
                end
            endcase
            write_reg(REG_WINDOW_SPAN, span_pick);
            write_reg(REG_MAX_ENTRIES, 36'(cap_pick));
            src_idle_pct   = (ph == 1) ? 88 : (ph == 3) ? 38 : 0;
            sink_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 38 : 0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && (ph == 0 || ph == 3)) begin
                    s_tvalid = 1'b0;
                    while (due_wr != due_rd) @(negedge aclk);
                end
                r   = $urandom_range(99);
                req = REQ_FRAME;
                if (r < 5) req = REQ_CLEAR;
                else if (r < 10) cur_ts = TS_W'({$urandom, $urandom});
                else if (r < 14) cur_ts = TS_W'(pick_below(64'(cur_ts) + 1));
                else if (r < 22) cur_ts = cur_ts;
                else if (r < 85) cur_ts = cur_ts + TS_W'(pick_below(64'(span_limit) / 8 + 2));
                else cur_ts = cur_ts + TS_W'(pick_below(64'(span_limit) * 2 + 2));
                r = $urandom_range(3);
                if (r < 2) size = $urandom;
                else if (r == 2) size = $urandom_range(2000);
                else size = $urandom_range(1) ? '1 : '0;
                push_item(req, size, cur_ts, 1'b0, '0);
            end
        end

        s_tvalid = 1'b0;
        while (due_wr != due_rd) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (mismatches == 0) begin
            $display("** sliding_window_frame_rate_meter_top: PASSED **");
        end else begin
            $display("** sliding_window_frame_rate_meter_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sliding_window_frame_rate_meter_top.f -----
src/swfrm_pkg.sv
src/swfrm_div.sv
src/sliding_window_frame_rate_meter_top.sv
src/swfrm_checker.sv
tb/sv/tb_sliding_window_frame_rate_meter_top.sv
